/* design/wfca_pkg.sv */
package wfca_pkg;

  localparam int CELL_W = 31;
  localparam int NUM_W  = 11;

  localparam logic OP_ALLOC = 1'b0;

  // Segment table write selections issued by the controller.
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_ALLOC = 2'd1;
  localparam logic [1:0] WR_SPLIT = 2'd2;
  localparam logic [1:0] WR_MERGE = 2'd3;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [NUM_W-1:0]  num_t;

  typedef struct packed {
    cell_t start;
    cell_t size;
    logic  free;
  } seg_t;

  typedef struct packed {
    cell_t start;
    logic  live;
  } log_t;

  typedef struct packed {
    logic       latch;
    logic       sc_start;
    logic [1:0] wsel;
    logic       sh_up;
    logic       sh_rm;
    logic       init_wr;
    logic       log_kill;
    logic       log_wr;
    logic       decide;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic num_ok;
    logic log_live;
    logic sc_busy;
    logic sh_busy;
    logic found;
    logic fail;
    logic split;
    logic out_busy;
  } status_t;

endpackage

/* design/wfca_ifs.sv */
interface wfca_in_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  wfca_pkg::cell_t      amount;
  wfca_pkg::num_t       request_number;

  modport source (output valid, output operation, output amount, output request_number,
                  input ready);
  modport sink (input valid, input operation, input amount, input request_number,
                output ready);
endinterface

interface wfca_out_if;
  logic            valid;
  logic            ready;
  wfca_pkg::cell_t first_cell;
  logic            failed;

  modport source (output valid, output first_cell, output failed, input ready);
  modport sink (input valid, input first_cell, input failed, output ready);
endinterface

/* design/wfca_ram.sv */
module wfca_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wfca_ctrl.sv */
module wfca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  wfca_pkg::status_t st,
  output wfca_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_ADEC = 4'd3;
  localparam logic [3:0] S_SHUP = 4'd4;
  localparam logic [3:0] S_SPLW = 4'd5;
  localparam logic [3:0] S_LRD  = 4'd6;
  localparam logic [3:0] S_LCHK = 4'd7;
  localparam logic [3:0] S_MRG  = 4'd8;
  localparam logic [3:0] S_RMV  = 4'd9;
  localparam logic [3:0] S_LOG  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.wsel  = wfca_pkg::WR_NONE;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (in_op == wfca_pkg::OP_ALLOC) begin
            cmd.sc_start = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_LRD;
          end
        end
      end
      S_LRD: begin
        state_nxt = st.num_ok ? S_LCHK : S_LOG;
      end
      S_LCHK: begin
        if (st.log_live) begin
          cmd.log_kill = 1'b1;
          cmd.sc_start = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_LOG;
        end
      end
      S_SCAN: begin
        if (!st.sc_busy) begin
          if (st.op == wfca_pkg::OP_ALLOC) begin
            state_nxt = S_ADEC;
          end else begin
            state_nxt = st.found ? S_MRG : S_LOG;
          end
        end
      end
      S_ADEC: begin
        cmd.decide = 1'b1;
        if (st.fail) begin
          state_nxt = S_LOG;
        end else begin
          cmd.wsel = wfca_pkg::WR_ALLOC;
          if (st.split) begin
            cmd.sh_up = 1'b1;
            state_nxt = S_SHUP;
          end else begin
            state_nxt = S_LOG;
          end
        end
      end
      S_SHUP: begin
        if (!st.sh_busy) begin
          state_nxt = S_SPLW;
        end
      end
      S_SPLW: begin
        cmd.wsel  = wfca_pkg::WR_SPLIT;
        state_nxt = S_LOG;
      end
      S_MRG: begin
        cmd.wsel  = wfca_pkg::WR_MERGE;
        cmd.sh_rm = 1'b1;
        state_nxt = S_RMV;
      end
      S_RMV: begin
        if (!st.sh_busy) begin
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        if (!(st.op == wfca_pkg::OP_ALLOC && st.out_busy)) begin
          cmd.log_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/wfca_dp.sv */
module wfca_dp #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_REQUESTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wfca_pkg::cmd_t     cmd,
  output wfca_pkg::status_t  st,
  input  logic               in_op,
  input  wfca_pkg::cell_t    in_amount,
  input  wfca_pkg::num_t     in_number,
  input  logic               cfg_we,
  input  wfca_pkg::cell_t    cfg_wdata,
  input  logic               out_ready,
  output logic               out_valid,
  output wfca_pkg::cell_t    out_first_cell,
  output logic               out_failed
);

  localparam int SAW = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int LAW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int RCW = $clog2(MAX_REQUESTS + 1);

  wfca_pkg::cell_t total_r;
  logic [CW-1:0]   seg_cnt_r;
  logic [RCW-1:0]  req_cnt_r;
  logic            op_r;
  wfca_pkg::cell_t amt_r;
  wfca_pkg::num_t  num_r;

  // Scan engine
  logic [CW-1:0]   sc_rd_r, sc_n_r, rk_r;
  logic            rv_r;
  logic            found_r;
  logic [CW-1:0]   idx_r;
  wfca_pkg::cell_t bstart_r, bsize_r;
  wfca_pkg::seg_t  prev_r, last_r;
  logic            nfree_r;
  wfca_pkg::cell_t nsize_r;
  wfca_pkg::cell_t s_r;

  // Shift engine
  logic [CW-1:0]   sh_rd_r, sh_n_r, pwa_r;
  logic            sh_up_r, pv_r;
  logic [1:0]      sh_d_r;

  wfca_pkg::cell_t res_start_r;
  logic            res_ok_r;
  logic            out_valid_r, out_failed_r;
  wfca_pkg::cell_t out_start_r;

  wfca_pkg::seg_t  seg_q, seg_wd;
  logic            seg_we;
  logic [SAW-1:0]  seg_wa, seg_ra;
  wfca_pkg::log_t  log_q, log_wd;
  logic            log_we;
  logic [LAW-1:0]  log_wa, log_ra;

  logic            sc_issue, sh_issue, hit_a, hit_f, fail, split;
  wfca_pkg::cell_t nadd, cur_sum, prev_sum;
  logic [1:0]      rm_d;
  logic [CW-1:0]   rm_lo;

  assign sc_issue = (sc_n_r != '0);
  assign sh_issue = (sh_n_r != '0);
  assign seg_ra   = sc_issue ? sc_rd_r[SAW-1:0] : sh_rd_r[SAW-1:0];

  assign hit_a = rv_r && (op_r == wfca_pkg::OP_ALLOC) && seg_q.free &&
                 (!found_r || seg_q.size > bsize_r);
  assign hit_f = rv_r && (op_r != wfca_pkg::OP_ALLOC) && !found_r &&
                 (seg_q.start == s_r) && !seg_q.free;

  assign split = (bsize_r > amt_r);
  assign fail  = (amt_r == '0) || !found_r || (bsize_r < amt_r) ||
                 (split && seg_cnt_r >= CW'(MAX_SEGMENTS));

  assign nadd     = nfree_r ? nsize_r : '0;
  assign cur_sum  = bsize_r + nadd;
  assign prev_sum = prev_r.size + cur_sum;
  assign rm_d     = (prev_r.free && nfree_r) ? 2'd2 : ((prev_r.free || nfree_r) ? 2'd1 : 2'd0);
  assign rm_lo    = (nfree_r && !prev_r.free) ? idx_r + CW'(1) : idx_r;

  always_comb begin
    seg_we = 1'b1;
    seg_wa = '0;
    seg_wd = '0;
    if (cfg_we) begin
      seg_wd = '{start: wfca_pkg::cell_t'(1), size: cfg_wdata, free: 1'b1};
    end else if (cmd.init_wr) begin
      seg_wd = '{start: wfca_pkg::cell_t'(1), size: total_r, free: 1'b1};
    end else if (pv_r) begin
      seg_wa = pwa_r[SAW-1:0];
      seg_wd = seg_q;
    end else begin
      case (cmd.wsel)
        wfca_pkg::WR_ALLOC: begin
          seg_wa = idx_r[SAW-1:0];
          seg_wd = '{start: bstart_r, size: amt_r, free: 1'b0};
        end
        wfca_pkg::WR_SPLIT: begin
          seg_wa = SAW'(idx_r + CW'(1));
          seg_wd = '{start: bstart_r + amt_r, size: bsize_r - amt_r, free: 1'b1};
        end
        wfca_pkg::WR_MERGE: begin
          if (prev_r.free) begin
            seg_wa = SAW'(idx_r - CW'(1));
            seg_wd = '{start: prev_r.start, size: prev_sum, free: 1'b1};
          end else begin
            seg_wa = idx_r[SAW-1:0];
            seg_wd = '{start: bstart_r, size: cur_sum, free: 1'b1};
          end
        end
        default: begin
          seg_we = 1'b0;
        end
      endcase
    end
  end

  // Request log: the kill write clears the live mark of the entry just read.
  assign log_ra = LAW'(32'(num_r) - 32'd1);
  always_comb begin
    log_we = 1'b0;
    log_wa = log_ra;
    log_wd = '{start: log_q.start, live: 1'b0};
    if (cmd.log_kill) begin
      log_we = 1'b1;
    end else if (cmd.log_wr && 32'(req_cnt_r) < 32'(MAX_REQUESTS)) begin
      log_we = 1'b1;
      log_wa = req_cnt_r[LAW-1:0];
      if (op_r == wfca_pkg::OP_ALLOC) begin
        log_wd = '{start: res_start_r, live: res_ok_r};
      end else begin
        log_wd = '{start: '0, live: 1'b0};
      end
    end
  end

  wfca_ram #(.W($bits(wfca_pkg::seg_t)), .D(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_wa), .wdata(seg_wd), .raddr(seg_ra), .rdata(seg_q)
  );

  wfca_ram #(.W($bits(wfca_pkg::log_t)), .D(MAX_REQUESTS)) u_log_ram (
    .clk(clk), .we(log_we), .waddr(log_wa), .wdata(log_wd), .raddr(log_ra), .rdata(log_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= wfca_pkg::cell_t'(1);
      seg_cnt_r   <= CW'(1);
      req_cnt_r   <= '0;
      sc_n_r      <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      sh_n_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= 1'b0;
    end else begin
      if (cmd.latch) begin
        op_r <= in_op;
      end
      if (cmd.sc_start) begin
        sc_n_r  <= seg_cnt_r;
        rv_r    <= 1'b0;
        found_r <= 1'b0;
      end else begin
        rv_r <= sc_issue;
        if (sc_issue) begin
          sc_n_r <= sc_n_r - CW'(1);
        end
        if (hit_a || hit_f) begin
          found_r <= 1'b1;
        end
      end
      pv_r <= sh_issue;
      if (cmd.sh_up) begin
        sh_n_r    <= seg_cnt_r - idx_r - CW'(1);
        seg_cnt_r <= seg_cnt_r + CW'(1);
      end else if (cmd.sh_rm) begin
        sh_n_r    <= (rm_d == 2'd0) ? '0 : seg_cnt_r - rm_lo - CW'(rm_d);
        seg_cnt_r <= seg_cnt_r - CW'(rm_d);
      end else if (sh_issue) begin
        sh_n_r <= sh_n_r - CW'(1);
      end
      if (cmd.log_wr && 32'(req_cnt_r) < 32'(MAX_REQUESTS)) begin
        req_cnt_r <= req_cnt_r + RCW'(1);
      end
      if (cmd.log_wr && op_r == wfca_pkg::OP_ALLOC) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        total_r   <= cfg_wdata;
        seg_cnt_r <= CW'(1);
        req_cnt_r <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      amt_r <= in_amount;
      num_r <= in_number;
    end
    if (cmd.sc_start) begin
      sc_rd_r     <= '0;
      last_r.free <= 1'b0;
      nfree_r     <= 1'b0;
    end else begin
      if (sc_issue) begin
        sc_rd_r <= sc_rd_r + CW'(1);
        rk_r    <= sc_rd_r;
      end
      if (hit_a || hit_f) begin
        idx_r    <= rk_r;
        bstart_r <= seg_q.start;
        bsize_r  <= seg_q.size;
        prev_r   <= last_r;
      end
      if (rv_r && found_r && rk_r == idx_r + CW'(1)) begin
        nfree_r <= seg_q.free;
        nsize_r <= seg_q.size;
      end
      if (rv_r) begin
        last_r <= seg_q;
      end
    end
    if (cmd.log_kill) begin
      s_r <= log_q.start;
    end
    if (cmd.sh_up) begin
      sh_rd_r <= seg_cnt_r - CW'(1);
      sh_up_r <= 1'b1;
      sh_d_r  <= 2'd1;
    end else if (cmd.sh_rm) begin
      sh_rd_r <= rm_lo + CW'(rm_d);
      sh_up_r <= 1'b0;
      sh_d_r  <= rm_d;
    end else if (sh_issue) begin
      pwa_r   <= sh_up_r ? sh_rd_r + CW'(1) : sh_rd_r - CW'(sh_d_r);
      sh_rd_r <= sh_up_r ? sh_rd_r - CW'(1) : sh_rd_r + CW'(1);
    end
    if (cmd.decide) begin
      res_start_r <= fail ? '0 : bstart_r;
      res_ok_r    <= !fail;
    end
    if (cmd.log_wr && op_r == wfca_pkg::OP_ALLOC) begin
      out_start_r  <= res_start_r;
      out_failed_r <= !res_ok_r;
    end
  end

  assign st.op       = op_r;
  assign st.num_ok   = (num_r != '0) && (32'(num_r) <= 32'(req_cnt_r));
  assign st.log_live = log_q.live;
  assign st.sc_busy  = sc_issue || rv_r;
  assign st.sh_busy  = sh_issue || pv_r;
  assign st.found    = found_r;
  assign st.fail     = fail;
  assign st.split    = split;
  assign st.out_busy = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_first_cell = out_start_r;
  assign out_failed     = out_failed_r;

endmodule

/* design/worst_fit_cell_allocator.sv */
// Channel   Dir  Word                                          Handshake
// in_word   in   operation, amount, request_number             valid/ready
// out_word  out  first_cell, failed (one per allocate only)    valid/ready
// cfg       in   cfg_wdata = total_cells                       cfg_we, no stall
//
// An allocate scans the whole segment table (one entry per cycle, set by the single
// read port of the segment RAM), then shifts the entries above a split up by one.
// A free reads the request log, scans the table and shifts entries down to drop the
// merged neighbors; a free with an invalid number or a dead log entry skips the scan.
// Reset is synchronous; after it the controller writes the first table entry, and then
// the block is ready. A waiting result does not block the next word: only the logging
// step of the next allocate waits until the output register has been taken.
module worst_fit_cell_allocator #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_REQUESTS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  wfca_in_if.sink          in_word,
  wfca_out_if.source       out_word,
  input  logic             cfg_we,
  input  wfca_pkg::cell_t  cfg_wdata
);

  // The controller sequences scan, decide, shift and log steps; the datapath owns
  // the segment table, the request log and the scan and shift engines.
  wfca_pkg::cmd_t    cmd;
  wfca_pkg::status_t st;

  wfca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_op    (in_word.operation),
    .in_ready (in_word.ready),
    .st       (st),
    .cmd      (cmd)
  );

  wfca_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_op          (in_word.operation),
    .in_amount      (in_word.amount),
    .in_number      (in_word.request_number),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_word.ready),
    .out_valid      (out_word.valid),
    .out_first_cell (out_word.first_cell),
    .out_failed     (out_word.failed)
  );

endmodule

/* dv/testbench.sv */
module testbench;

  localparam int SEG_DEPTH  = 256;
  localparam int LOG_DEPTH  = 1024;
  // An allocate or free scans the table and then shifts it.
  // A free produces no result, so settling waits SETTLE_CYCLES before a config write.
  localparam int SETTLE_CYCLES = 600;
  localparam int LONG_HOLD     = 2000;
  localparam wfca_pkg::cell_t CELL_MAX = 31'h7FFF_FFFF;
  localparam logic OP_FREE     = ~wfca_pkg::OP_ALLOC;

  // The result the block owes for one allocate word.
  typedef struct {
    wfca_pkg::cell_t first_cell;
    logic            failed;
  } grant_t;

  // Shadow copy of the allocator: the segment table ordered by start cell and
  // the log of numbered requests. It predicts one grant per allocate word and
  // checks every result word against the oldest grant still owed.
  class cell_map_tracker;
    wfca_pkg::cell_t total_cells;
    wfca_pkg::seg_t  segs[SEG_DEPTH];
    int              seg_count;
    wfca_pkg::cell_t log_start[LOG_DEPTH];
    bit              log_live[LOG_DEPTH];
    int              req_count;
    grant_t          owed_grants[$];
    int              errors;

    function void rebuild(wfca_pkg::cell_t cells);
      total_cells = cells;
      foreach (segs[i]) segs[i] = '0;
      foreach (log_live[i]) begin
        log_live[i]  = 1'b0;
        log_start[i] = '0;
      end
      segs[0].start = 1;
      segs[0].size  = cells;
      segs[0].free  = 1'b1;
      seg_count = 1;
      req_count = 0;
    endfunction

    function void drop_seg(int idx);
      for (int i = idx; i < seg_count - 1; i++) segs[i] = segs[i+1];
      seg_count--;
    endfunction

    // Worst fit: the largest free segment wins, the lowest start on a tie.
    function wfca_pkg::cell_t take_largest(wfca_pkg::cell_t amount);
      int              best;
      wfca_pkg::cell_t best_size;
      wfca_pkg::cell_t base;
      bit              found;
      best = 0;
      best_size = '0;
      found = 1'b0;
      for (int i = 0; i < seg_count; i++) begin
        if (segs[i].free && (!found || segs[i].size > best_size)) begin
          found = 1'b1;
          best = i;
          best_size = segs[i].size;
        end
      end
      if (amount == 0 || !found || best_size < amount) return '0;
      // A split that needs a new entry in a full table fails.
      if (best_size > amount && seg_count >= SEG_DEPTH) return '0;
      base = segs[best].start;
      segs[best].size = amount;
      segs[best].free = 1'b0;
      if (best_size > amount) begin
        for (int i = seg_count; i > best + 1; i--) segs[i] = segs[i-1];
        segs[best+1].start = base + amount;
        segs[best+1].size  = best_size - amount;
        segs[best+1].free  = 1'b1;
        seg_count++;
      end
      return base;
    endfunction

    function void give_back(int number);
      int              r;
      int              idx;
      wfca_pkg::cell_t base;
      if (number == 0 || number > req_count) return;
      r = number - 1;
      if (!log_live[r]) return;
      log_live[r] = 1'b0;
      base = log_start[r];
      idx = -1;
      for (int i = 0; i < seg_count; i++) begin
        if (segs[i].start == base && !segs[i].free) begin
          idx = i;
          break;
        end
      end
      if (idx < 0) return;
      segs[idx].free = 1'b1;
      // Merge with the free neighbor above, then with the one below.
      if (idx + 1 < seg_count && segs[idx+1].free) begin
        segs[idx].size = segs[idx].size + segs[idx+1].size;
        drop_seg(idx + 1);
      end
      if (idx > 0 && segs[idx-1].free) begin
        segs[idx-1].size = segs[idx-1].size + segs[idx].size;
        drop_seg(idx);
      end
    endfunction

    function void log_request(wfca_pkg::cell_t base, bit live);
      // Once the log is full, requests are carried out but never logged.
      if (req_count < LOG_DEPTH) begin
        log_start[req_count] = base;
        log_live[req_count]  = live;
        req_count++;
      end
    endfunction

    function void note_request(logic op, wfca_pkg::cell_t amount, wfca_pkg::num_t number);
      grant_t          g;
      wfca_pkg::cell_t base;
      if (op == wfca_pkg::OP_ALLOC) begin
        base = take_largest(amount);
        log_request(base, base != 0);
        g.first_cell = base;
        g.failed = (base == 0);
        owed_grants.insert(owed_grants.size(), g);
      end else begin
        give_back(number);
        log_request('0, 1'b0);
      end
    endfunction

    function void check_grant(wfca_pkg::cell_t first_cell, logic failed);
      grant_t g;
      if (owed_grants.size() == 0) begin
        $display("%0t: result with none owed: first_cell %0d failed %0b",
                 $time, first_cell, failed);
        errors++;
        return;
      end
      g = owed_grants.pop_front();
      if (first_cell !== g.first_cell) begin
        $display("%0t: first_cell expected %0d actual %0d", $time, g.first_cell, first_cell);
        errors++;
      end
      if (failed !== g.failed) begin
        $display("%0t: failed expected %0b actual %0b", $time, g.failed, failed);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  wfca_pkg::cell_t cfg_wdata;

  wfca_in_if  in_ch();
  wfca_out_if out_ch();

  cell_map_tracker tracker;
  // Count of requests numbered since the last rebuild, used to aim free words.
  int issued;
  int results_taken;

  worst_fit_cell_allocator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous upper bound: about 2000 words plus their gaps, the long receiver hold
  // and the settling pauses, taken several times.
  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end

  // Both monitors sample at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_request(in_ch.operation, in_ch.amount, in_ch.request_number);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_grant(out_ch.first_cell, out_ch.failed);
      results_taken++;
    end
  end

  // Receiver: a random hold before each result word, and one long hold once 500
  // results are in, so the block backs up and stalls its input.
  initial begin
    int hold;
    bit held_long;
    held_long = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(0, 3);
      if (!held_long && results_taken >= 500) begin
        held_long = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one word after a random gap and wait until it is taken.
  // Valid stays high across back-to-back words, so it is never dropped and
  // raised in the same step.
  task automatic send_word(logic op, wfca_pkg::cell_t amount, wfca_pkg::num_t number);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.amount         <= amount;
    in_ch.request_number <= number;
    do @(posedge clk); while (!in_ch.ready);
    issued++;
  endtask

  task automatic alloc_cells(wfca_pkg::cell_t amount);
    send_word(wfca_pkg::OP_ALLOC, amount, wfca_pkg::num_t'($urandom));
  endtask

  task automatic free_request(wfca_pkg::num_t number);
    send_word(OP_FREE, wfca_pkg::cell_t'($urandom), number);
  endtask

  // Wait until every owed result is in, then let any trailing free finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite total_cells; the block rebuilds its table and log as on reset.
  task automatic set_total(wfca_pkg::cell_t cells);
    drain();
    cfg_wdata <= cells;
    cfg_we    <= 1'b1;
    @(posedge clk);
    tracker.rebuild(cells);
    cfg_we <= 1'b0;
    @(posedge clk);
    issued = 0;
  endtask

  // Random word: mostly allocates; a free is aimed at an issued number when the pick is under 95.
  // alloc_pct sets the mix; unit_amounts favors one-cell allocations that
  // fill the segment table.
  task automatic random_word(int alloc_pct, bit unit_amounts, wfca_pkg::cell_t span);
    int              pick;
    wfca_pkg::cell_t amount;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      case ($urandom_range(0, 19))
        0:       amount = wfca_pkg::cell_t'($urandom);
        1:       amount = '0;
        2:       amount = CELL_MAX;
        default: amount = unit_amounts ? wfca_pkg::cell_t'(1)
                                       : wfca_pkg::cell_t'($urandom_range(1, span));
      endcase
      alloc_cells(amount);
    end else if (pick < 95 && issued > 0) begin
      free_request(wfca_pkg::num_t'($urandom_range(1, issued > 2047 ? 2047 : issued)));
    end else begin
      free_request(wfca_pkg::num_t'($urandom_range(0, 2047)));
    end
  endtask

  initial begin
    tracker = new();
    tracker.rebuild(1);
    issued = 0;
    results_taken = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = wfca_pkg::OP_ALLOC;
    in_ch.amount = '0;
    in_ch.request_number = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One cell after reset: grant, exhaustion, zero amount, and the bad frees.
    alloc_cells(1);
    alloc_cells(1);
    alloc_cells(0);
    free_request(1);
    free_request(1);        // double free is ignored
    free_request(0);        // number zero is ignored
    free_request(2047);     // number not yet issued
    free_request(2);        // names a failed allocation
    free_request(4);        // names a free request
    alloc_cells(2);
    alloc_cells(1);

    // Largest pool possible: all cells in one grant, then no fit at all.
    set_total(CELL_MAX);
    alloc_cells(CELL_MAX);
    alloc_cells(CELL_MAX);
    free_request(1);
    alloc_cells(CELL_MAX - 1);

    // Ten cells: worst fit picks the tail segment over the freed head.
    set_total(10);
    alloc_cells(3);
    alloc_cells(3);
    free_request(1);
    alloc_cells(3);

    // Six cells: two free segments of equal size, the lower start must win.
    set_total(6);
    alloc_cells(2);
    alloc_cells(2);
    free_request(1);
    alloc_cells(2);
    free_request(2);        // merges only with the free tail segment above

    // No cells at all: every allocation fails.
    set_total(0);
    alloc_cells(1);

    // Small pool with mixed sizes, lots of splitting and coalescing.
    set_total(wfca_pkg::cell_t'($urandom_range(1, 2000)));
    repeat (400) random_word(60, 1'b0, 64);

    // A pool of 300 cells taken one at a time runs the segment table full.
    set_total(300);
    repeat (300) random_word(92, 1'b1, 1);
    repeat (100) random_word(55, 1'b1, 1);

    // Huge pool and enough words to run the request log past full.
    set_total(CELL_MAX);
    repeat (1150) random_word(65, 1'b0, 31'h0100_0000);

    drain();
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
